@@ rtl/vgc_pkg.sv @@
// vgc_pkg: types and constants of the vowel group classifier.
// Holds the port word structs, letter codes, group codes and the work struct
// used by vowel_group_classifier_top. Depends on nothing.
package vgc_pkg;

  // Letter codes tested by the classifier
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_O = 8'h6f;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_X = 8'h78;

  // Reset values of the configured vowel codes
  localparam logic [7:0] RST_A_BREVE      = 8'd227;
  localparam logic [7:0] RST_A_CIRCUMFLEX = 8'd226;
  localparam logic [7:0] RST_I_CIRCUMFLEX = 8'd238;

  // Configuration register indexes
  localparam logic [1:0] REG_A_BREVE      = 2'd0;
  localparam logic [1:0] REG_A_CIRCUMFLEX = 2'd1;
  localparam logic [1:0] REG_I_CIRCUMFLEX = 2'd2;

  // Sound-group codes
  localparam logic [2:0] GRP_CONS  = 3'd0;
  localparam logic [2:0] GRP_VOWEL = 3'd1;
  localparam logic [2:0] GRP_DIPH  = 3'd2;
  localparam logic [2:0] GRP_TRIPH = 3'd3;
  localparam logic [2:0] GRP_CHGH  = 3'd4;
  localparam logic [2:0] GRP_X     = 3'd5;

  // c/g lookahead codes
  localparam logic [1:0] CG_NONE = 2'd0;
  localparam logic [1:0] CG_SEEN = 2'd1;
  localparam logic [1:0] CG_H    = 2'd2;

  // Triphthong table answers
  localparam logic [1:0] TRI_NO  = 2'd0;
  localparam logic [1:0] TRI_YES = 2'd1;
  localparam logic [1:0] TRI_ERR = 2'd2;

  localparam int RUN_DEPTH   = 5;
  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0] group;
    logic       error;
    logic       last_of_item;
    logic       word_done;
  } out_word_t;

  typedef struct packed {
    logic [7:0] a_breve;
    logic [7:0] a_circumflex;
    logic [7:0] i_circumflex;
  } cfg_t;

  // Classifier state plus the results gathered for one letter
  typedef struct packed {
    logic [RUN_DEPTH-1:0][7:0]   run;
    logic [2:0]                  len;
    logic [1:0]                  pcg;
    logic [MAX_RESULTS-1:0][2:0] grp;
    logic [2:0]                  count;
    logic                        failed;
  } work_t;

endpackage

@@ rtl/vowel_group_classifier_top.sv @@
// vowel_group_classifier_top: letter-by-letter sound-group classifier.
// Uses vgc_pkg for port words, letter and group codes and the work struct.
// Channels:
//   channel  | side | handshake          | word
//   ---------+------+--------------------+------------------------------------
//   letter   | in   | letter_valid/stall | vgc_pkg::in_word_t  (letter, end)
//   result   | out  | result_valid/stall | vgc_pkg::out_word_t (group, flags)
//   cfg      | in   | cfg_valid/ready    | cfg_index (2 bits), cfg_data (8)
// Flow: a letter word is held in the input register, is classified
// in one pass of table logic and lands in the result bundle register.
// Each letter makes zero to four result words; the result port sends one
// per cycle while result_stall is low.
// The bundle register is the pacing point: a letter with one result or
// none moves on every cycle unless the result port stalls. Reset (rst, synchronous) empties both stages,
// clears the run, the c/g lookahead and the drop flag, and restores the
// three vowel codes. A stalled result port holds the bundle and, behind it,
// the input register; cfg writes are always ready.
module vowel_group_classifier_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               letter_valid,
  output logic               letter_stall,
  input  vgc_pkg::in_word_t  letter,
  output logic               result_valid,
  input  logic               result_stall,
  output vgc_pkg::out_word_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // ---------------------------------------------------------------------
  // Table functions
  // ---------------------------------------------------------------------
  function automatic logic is_vow(logic [7:0] c, vgc_pkg::cfg_t cf);
    return c == vgc_pkg::CH_A || c == vgc_pkg::CH_E || c == vgc_pkg::CH_I ||
           c == vgc_pkg::CH_O || c == vgc_pkg::CH_U || c == cf.a_breve ||
           c == cf.a_circumflex || c == cf.i_circumflex;
  endfunction

  // Diphthong table
  function automatic logic di(logic [7:0] a, logic [7:0] b, vgc_pkg::cfg_t cf);
    logic r;
    r = 1'b0;
    if (a == vgc_pkg::CH_A) begin
      r = b == vgc_pkg::CH_I || b == vgc_pkg::CH_U;
    end else if (a == vgc_pkg::CH_E) begin
      r = b == vgc_pkg::CH_A || b == vgc_pkg::CH_O || b == vgc_pkg::CH_I ||
          b == vgc_pkg::CH_U;
    end else if (a == vgc_pkg::CH_I) begin
      r = b == vgc_pkg::CH_A || b == vgc_pkg::CH_E || b == vgc_pkg::CH_O ||
          b == vgc_pkg::CH_U || b == vgc_pkg::CH_I;
    end else if (a == vgc_pkg::CH_O) begin
      r = b == vgc_pkg::CH_A || b == vgc_pkg::CH_I || b == vgc_pkg::CH_U;
    end else if (a == vgc_pkg::CH_U) begin
      r = b == vgc_pkg::CH_A || b == cf.a_breve || b == vgc_pkg::CH_I;
    end else if (a == cf.a_breve || a == cf.a_circumflex) begin
      r = b == vgc_pkg::CH_I || b == vgc_pkg::CH_U;
    end
    return r;
  endfunction

  // Triphthong table: no, yes, or no rule at all
  function automatic logic [1:0] tri3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [1:0] r;
    r = vgc_pkg::TRI_NO;
    if (a == vgc_pkg::CH_E) begin
      r = vgc_pkg::TRI_ERR;
      if (b == vgc_pkg::CH_A && (c == vgc_pkg::CH_I || c == vgc_pkg::CH_U))
        r = vgc_pkg::TRI_YES;
      if (b == vgc_pkg::CH_O && c == vgc_pkg::CH_A)
        r = vgc_pkg::TRI_YES;
    end else if (a == vgc_pkg::CH_I) begin
      r = vgc_pkg::TRI_ERR;
      if (b == vgc_pkg::CH_A && (c == vgc_pkg::CH_I || c == vgc_pkg::CH_U))
        r = vgc_pkg::TRI_YES;
      if (b == vgc_pkg::CH_E && c == vgc_pkg::CH_I)
        r = vgc_pkg::TRI_YES;
      if (b == vgc_pkg::CH_O && c == vgc_pkg::CH_A)
        r = vgc_pkg::TRI_YES;
    end else if (a == vgc_pkg::CH_O) begin
      r = (b == vgc_pkg::CH_A && c == vgc_pkg::CH_I) ? vgc_pkg::TRI_YES
                                                     : vgc_pkg::TRI_ERR;
    end
    return r;
  endfunction

  // Append one result; drop it once the bundle is full
  function automatic vgc_pkg::work_t push(vgc_pkg::work_t w, logic [2:0] g);
    vgc_pkg::work_t r;
    r = w;
    if (w.count < 3'(vgc_pkg::MAX_RESULTS)) begin
      r.grp[w.count[1:0]] = g;
      r.count = w.count + 3'd1;
    end
    return r;
  endfunction

  function automatic vgc_pkg::work_t push_err(vgc_pkg::work_t w);
    vgc_pkg::work_t r;
    r = push(w, vgc_pkg::GRP_CONS);
    r.failed = 1'b1;
    return r;
  endfunction

  // Split the held vowel run into groups
  function automatic vgc_pkg::work_t flush(vgc_pkg::work_t w, vgc_pkg::cfg_t cf);
    vgc_pkg::work_t r;
    logic [1:0]     t;
    r = w;
    case (w.len)
      3'd0: begin
      end
      3'd1: r = push(r, vgc_pkg::GRP_VOWEL);
      3'd2: begin
        if (di(w.run[0], w.run[1], cf)) begin
          r = push(r, vgc_pkg::GRP_DIPH);
        end else begin
          r = push(r, vgc_pkg::GRP_VOWEL);
          r = push(r, vgc_pkg::GRP_VOWEL);
        end
      end
      3'd3: begin
        t = tri3(w.run[0], w.run[1], w.run[2]);
        if (t == vgc_pkg::TRI_YES) begin
          r = push(r, vgc_pkg::GRP_TRIPH);
        end else if (t == vgc_pkg::TRI_NO && di(w.run[1], w.run[2], cf)) begin
          r = push(r, vgc_pkg::GRP_VOWEL);
          r = push(r, vgc_pkg::GRP_DIPH);
        end else begin
          r = push_err(r);
        end
      end
      3'd4: begin
        t = tri3(w.run[1], w.run[2], w.run[3]);
        if (t == vgc_pkg::TRI_YES) begin
          r = push(r, vgc_pkg::GRP_VOWEL);
          r = push(r, vgc_pkg::GRP_TRIPH);
        end else if (t == vgc_pkg::TRI_NO && di(w.run[0], w.run[1], cf) &&
                     di(w.run[2], w.run[3], cf)) begin
          r = push(r, vgc_pkg::GRP_DIPH);
          r = push(r, vgc_pkg::GRP_DIPH);
        end else begin
          r = push_err(r);
        end
      end
      default: begin
        if (di(w.run[0], w.run[1], cf) &&
            tri3(w.run[2], w.run[3], w.run[4]) == vgc_pkg::TRI_YES) begin
          r = push(r, vgc_pkg::GRP_DIPH);
          r = push(r, vgc_pkg::GRP_TRIPH);
        end else begin
          r = push_err(r);
        end
      end
    endcase
    r.len = 3'd0;
    return r;
  endfunction

  // Ordinary handling of one letter with no c/g pending
  function automatic vgc_pkg::work_t feed(vgc_pkg::work_t w, logic [7:0] c,
                                          vgc_pkg::cfg_t cf);
    vgc_pkg::work_t r;
    r = w;
    if (!w.failed) begin
      if (is_vow(c, cf)) begin
        if (w.len >= 3'(vgc_pkg::RUN_DEPTH)) begin
          r = push_err(r);
        end else begin
          r.run[w.len] = c;
          r.len = w.len + 3'd1;
        end
      end else begin
        r = flush(r, cf);
        if (!r.failed) begin
          if (c == vgc_pkg::CH_X)
            r = push(r, vgc_pkg::GRP_X);
          else if (c == vgc_pkg::CH_C || c == vgc_pkg::CH_G)
            r.pcg = vgc_pkg::CG_SEEN;
          else
            r = push(r, vgc_pkg::GRP_CONS);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  vgc_pkg::cfg_t    cfg;
  vgc_pkg::in_word_t in_reg;
  logic             in_full;

  logic [vgc_pkg::RUN_DEPTH-1:0][7:0] run;
  logic [2:0]       run_len;
  logic [1:0]       pcg;
  logic             drop;

  // Result bundle: up to four groups of one letter, sent one per cycle unless the result port stalls
  logic                                b_valid;
  logic [vgc_pkg::MAX_RESULTS-1:0][2:0] b_grp;
  logic [1:0]                          b_idx;
  logic [1:0]                          b_last;
  logic                                b_err;
  logic                                b_done;

  // ---------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------
  logic out_go;
  logic b_ending;
  logic advance;
  logic item_go;

  assign out_go   = b_valid && !result_stall;
  assign b_ending = out_go && b_idx == b_last;
  assign advance  = !b_valid || b_ending;
  assign item_go  = in_full && advance;

  assign letter_stall = in_full && !advance;
  assign cfg_ready    = 1'b1;

  // ---------------------------------------------------------------------
  // Classification pass
  // ---------------------------------------------------------------------
  vgc_pkg::work_t w;
  logic           drop_next;

  always_comb begin
    w        = '0;
    w.run    = run;
    w.len    = run_len;
    w.pcg    = pcg;
    drop_next = drop;
    if (drop) begin
      // skip the rest of an aborted word; its last letter is skipped too and clears the drop flag
      if (in_reg.end_of_word) drop_next = 1'b0;
    end else begin
      case (pcg)
        vgc_pkg::CG_SEEN: begin
          if (in_reg.char_code == vgc_pkg::CH_H) begin
            w.pcg = vgc_pkg::CG_H;
          end else begin
            w.pcg = vgc_pkg::CG_NONE;
            w = push(w, vgc_pkg::GRP_CONS);
            w = feed(w, in_reg.char_code, cfg);
          end
        end
        vgc_pkg::CG_H: begin
          w.pcg = vgc_pkg::CG_NONE;
          if (in_reg.char_code == vgc_pkg::CH_E || in_reg.char_code == vgc_pkg::CH_I) begin
            w = push(w, vgc_pkg::GRP_CHGH);
          end else begin
            w = push(w, vgc_pkg::GRP_CONS);
            w = feed(w, vgc_pkg::CH_H, cfg);
            w = feed(w, in_reg.char_code, cfg);
          end
        end
        default: w = feed(w, in_reg.char_code, cfg);
      endcase

      // close the word: settle the lookahead, then the vowel run
      if (in_reg.end_of_word && !w.failed) begin
        if (w.pcg == vgc_pkg::CG_SEEN) begin
          w.pcg = vgc_pkg::CG_NONE;
          w = push(w, vgc_pkg::GRP_CONS);
        end else if (w.pcg == vgc_pkg::CG_H) begin
          w.pcg = vgc_pkg::CG_NONE;
          w = push(w, vgc_pkg::GRP_CONS);
          w = feed(w, vgc_pkg::CH_H, cfg);
        end
        if (!w.failed) w = flush(w, cfg);
      end

      if (w.failed) begin
        w.len     = 3'd0;
        w.pcg     = vgc_pkg::CG_NONE;
        drop_next = !in_reg.end_of_word;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Clocked state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_breve      <= vgc_pkg::RST_A_BREVE;
      cfg.a_circumflex <= vgc_pkg::RST_A_CIRCUMFLEX;
      cfg.i_circumflex <= vgc_pkg::RST_I_CIRCUMFLEX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vgc_pkg::REG_A_BREVE:      cfg.a_breve      <= cfg_data;
        vgc_pkg::REG_A_CIRCUMFLEX: cfg.a_circumflex <= cfg_data;
        vgc_pkg::REG_I_CIRCUMFLEX: cfg.i_circumflex <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: take a letter whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (letter_valid && !letter_stall) begin
      in_full <= 1'b1;
    end else if (item_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (letter_valid && !letter_stall) in_reg <= letter;
  end

  // Classifier state advances as each letter leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= 3'd0;
      pcg     <= vgc_pkg::CG_NONE;
      drop    <= 1'b0;
    end else if (item_go) begin
      run_len <= w.len;
      pcg     <= w.pcg;
      drop    <= drop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) run <= w.run;
  end

  // Result bundle: reload on a new letter with results, else pop one word per accepted output
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= 2'd0;
    end else if (item_go && w.count != 3'd0) begin
      b_valid <= 1'b1;
      b_idx   <= 2'd0;
    end else if (out_go) begin
      if (b_ending) b_valid <= 1'b0;
      else          b_idx   <= b_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && w.count != 3'd0) begin
      b_grp  <= w.grp;
      b_last <= 2'(w.count - 3'd1);
      b_err  <= w.failed;
      b_done <= in_reg.end_of_word || w.failed;
    end
  end

  // ---------------------------------------------------------------------
  // Result port
  // ---------------------------------------------------------------------
  logic last_word;
  assign last_word = b_idx == b_last;

  assign result_valid        = b_valid;
  assign result.group        = b_grp[b_idx];
  assign result.error        = b_err && last_word;
  assign result.last_of_item = last_word;
  assign result.word_done    = b_done && last_word;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> b_idx <= b_last)
    else $error("bundle index past its last word");

  a_err_ends_word: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_err |-> b_done)
    else $error("error bundle does not end the word");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_len <= 3'(vgc_pkg::RUN_DEPTH))
    else $error("vowel run longer than its store");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_reg))
    else $error("held letter lost or changed");

endmodule
